// ===== rtl/core/mqttpd_pkg.sv =====
package mqttpd_pkg;

	// Parser phase, one-hot
	typedef enum logic [6:0] {
		PH_HEADER  = 7'b0000001,
		PH_LENGTH  = 7'b0000010,
		PH_TLEN_HI = 7'b0000100,
		PH_TLEN_LO = 7'b0001000,
		PH_TOPIC   = 7'b0010000,
		PH_PAYLOAD = 7'b0100000,
		PH_SKIP    = 7'b1000000
	} phase_t;

	// Byte role codes
	typedef logic [2:0] role_t;
	localparam role_t ROLE_HEADER  = 3'd0;
	localparam role_t ROLE_LENGTH  = 3'd1;
	localparam role_t ROLE_TLEN    = 3'd2;
	localparam role_t ROLE_TOPIC   = 3'd3;
	localparam role_t ROLE_PAYLOAD = 3'd4;
	localparam role_t ROLE_SKIP    = 3'd5;
	localparam role_t ROLE_DROP    = 3'd6;

	localparam logic [3:0] TYPE_PUBLISH = 4'd3;

	localparam int BODY_W  = 28;
	localparam int TOPIC_W = 16;

	typedef logic [BODY_W-1:0]  body_len_t;
	typedef logic [TOPIC_W-1:0] topic_len_t;

endpackage

// ===== rtl/core/mqtt_packet_deframer.sv =====
// MQTT 3.1.1 packet deframer.
// Slave stream (s_axis_*) takes one raw byte of the MQTT stream per
// transaction. Master stream (m_axis_*) returns exactly one tagged result per
// input byte: the byte itself, its role in the packet, the packet type, the
// decoded remaining length and PUBLISH topic length, plus end/drop/malformed
// flags. m_axis_tlast marks the last byte of an accepted packet.
// Results are registered and appear in the cycle after their input byte.
// Throughput: one byte per cycle unless the receiver stalls; the per-byte parser
// state update is a single pass of logic between the state registers and the
// result register. The result register doubles as the decoupling stage: a new
// byte is taken whenever the result register is empty or is being drained in
// the same cycle. When the receiver stalls (m_axis_tready low with a result
// pending), s_axis_tready drops and the pending result holds until taken.
// Reset (arst_n low, asynchronous) returns the parser to the header phase,
// clears all tracked lengths and empties the result register.
// Remaining length is a base-128 varint of up to MAX_LENGTH_BYTES bytes; a
// continuation bit on the last allowed byte flags length_malformed and the
// next byte is taken as a new header.
module mqtt_packet_deframer #(
	parameter int MAX_LENGTH_BYTES = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [7:0] byte_value, [35:8] body_length, [51:36] topic_length, [55:52] zero
	output logic [55:0] m_axis_tdata,
	// [2:0] byte_role, [6:3] packet_type, [7] packet_dropped, [8] length_malformed
	output logic [8:0]  m_axis_tuser,
	output logic        m_axis_tlast    // packet_end
);

	localparam logic [2:0] MAX_SEEN = 3'(MAX_LENGTH_BYTES);

	// parser state
	mqttpd_pkg::phase_t     phase_q, phase_d;
	logic [3:0]             type_q, type_d;
	mqttpd_pkg::body_len_t  accum_q, accum_d;
	logic [2:0]             seen_q, seen_d;
	mqttpd_pkg::body_len_t  left_q, left_d;
	mqttpd_pkg::topic_len_t tlen_q, tlen_d;
	mqttpd_pkg::topic_len_t tleft_q, tleft_d;
	logic                   bad_q, bad_d;

	// per-byte result
	mqttpd_pkg::role_t      role_d;
	logic                   end_d, drop_d, mal_d;

	// result register
	logic                   out_valid_q;
	logic [7:0]             val_q;
	mqttpd_pkg::role_t      role_q;
	logic [3:0]             otype_q;
	logic                   end_q, drop_q, mal_q;
	mqttpd_pkg::body_len_t  olen_q;
	mqttpd_pkg::topic_len_t otlen_q;

	logic                   accept;
	logic [7:0]             b;
	mqttpd_pkg::body_len_t  grp;
	mqttpd_pkg::body_len_t  left_dec;
	logic [2:0]             seen_inc;

	assign s_axis_tready = !out_valid_q || m_axis_tready;
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign b             = s_axis_tdata;
	assign left_dec      = left_q - 28'd1;
	assign seen_inc      = seen_q + 3'd1;

	// 7-bit group placed at its varint position
	always_comb begin
		case (seen_q[1:0])
			2'd0:    grp = {21'd0, b[6:0]};
			2'd1:    grp = {14'd0, b[6:0], 7'd0};
			2'd2:    grp = {7'd0, b[6:0], 14'd0};
			default: grp = {b[6:0], 21'd0};
		endcase
	end

	always_comb begin
		phase_d = phase_q;
		type_d  = type_q;
		accum_d = accum_q;
		seen_d  = seen_q;
		left_d  = left_q;
		tlen_d  = tlen_q;
		tleft_d = tleft_q;
		bad_d   = bad_q;
		role_d  = mqttpd_pkg::ROLE_HEADER;
		end_d   = 1'b0;
		drop_d  = 1'b0;
		mal_d   = 1'b0;
		unique case (phase_q)
			mqttpd_pkg::PH_LENGTH: begin
				role_d  = mqttpd_pkg::ROLE_LENGTH;
				accum_d = accum_q | grp;
				seen_d  = seen_inc;
				if (b[7]) begin
					if (seen_inc >= MAX_SEEN) begin
						mal_d   = 1'b1;
						phase_d = mqttpd_pkg::PH_HEADER;
					end
				end else begin
					left_d = accum_q | grp;
					if ((accum_q | grp) == '0) begin
						if (type_q == mqttpd_pkg::TYPE_PUBLISH) drop_d = 1'b1;
						else end_d = 1'b1;
						phase_d = mqttpd_pkg::PH_HEADER;
					end else if (type_q == mqttpd_pkg::TYPE_PUBLISH) begin
						phase_d = mqttpd_pkg::PH_TLEN_HI;
					end else begin
						phase_d = mqttpd_pkg::PH_SKIP;
					end
				end
			end
			mqttpd_pkg::PH_TLEN_HI: begin
				role_d = mqttpd_pkg::ROLE_TLEN;
				tlen_d = {b, 8'd0};
				left_d = left_dec;
				if (left_dec == '0) begin
					drop_d  = 1'b1;
					phase_d = mqttpd_pkg::PH_HEADER;
				end else begin
					phase_d = mqttpd_pkg::PH_TLEN_LO;
				end
			end
			mqttpd_pkg::PH_TLEN_LO: begin
				role_d  = mqttpd_pkg::ROLE_TLEN;
				tlen_d  = {tlen_q[15:8], b};
				tleft_d = {tlen_q[15:8], b};
				left_d  = left_dec;
				if ({12'd0, tlen_q[15:8], b} > left_dec) begin
					bad_d = 1'b1;
					if (left_dec == '0) begin
						drop_d  = 1'b1;
						phase_d = mqttpd_pkg::PH_HEADER;
					end else begin
						phase_d = mqttpd_pkg::PH_SKIP;
					end
				end else if (left_dec == '0) begin
					end_d   = 1'b1;
					phase_d = mqttpd_pkg::PH_HEADER;
				end else if ({tlen_q[15:8], b} != '0) begin
					phase_d = mqttpd_pkg::PH_TOPIC;
				end else begin
					phase_d = mqttpd_pkg::PH_PAYLOAD;
				end
			end
			mqttpd_pkg::PH_TOPIC: begin
				role_d  = mqttpd_pkg::ROLE_TOPIC;
				tleft_d = tleft_q - 16'd1;
				left_d  = left_dec;
				if (left_dec == '0) begin
					end_d   = 1'b1;
					phase_d = mqttpd_pkg::PH_HEADER;
				end else if (tleft_q == 16'd1) begin
					phase_d = mqttpd_pkg::PH_PAYLOAD;
				end
			end
			mqttpd_pkg::PH_PAYLOAD: begin
				role_d = mqttpd_pkg::ROLE_PAYLOAD;
				left_d = left_dec;
				if (left_dec == '0) begin
					end_d   = 1'b1;
					phase_d = mqttpd_pkg::PH_HEADER;
				end
			end
			mqttpd_pkg::PH_SKIP: begin
				role_d = bad_q ? mqttpd_pkg::ROLE_DROP : mqttpd_pkg::ROLE_SKIP;
				left_d = left_dec;
				if (left_dec == '0) begin
					if (bad_q) drop_d = 1'b1;
					else end_d = 1'b1;
					phase_d = mqttpd_pkg::PH_HEADER;
				end
			end
			default: begin
				// header byte: start a new packet
				role_d  = mqttpd_pkg::ROLE_HEADER;
				type_d  = b[7:4];
				accum_d = '0;
				seen_d  = '0;
				left_d  = '0;
				tlen_d  = '0;
				tleft_d = '0;
				bad_d   = 1'b0;
				phase_d = mqttpd_pkg::PH_LENGTH;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= mqttpd_pkg::PH_HEADER;
			type_q  <= '0;
			accum_q <= '0;
			seen_q  <= '0;
			left_q  <= '0;
			tlen_q  <= '0;
			tleft_q <= '0;
			bad_q   <= 1'b0;
		end else if (accept) begin
			phase_q <= phase_d;
			type_q  <= type_d;
			accum_q <= accum_d;
			seen_q  <= seen_d;
			left_q  <= left_d;
			tlen_q  <= tlen_d;
			tleft_q <= tleft_d;
			bad_q   <= bad_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s_axis_tready) begin
			out_valid_q <= s_axis_tvalid;
		end
	end

	// payload of the result register
	always_ff @(posedge clk) begin
		if (accept) begin
			val_q   <= b;
			role_q  <= role_d;
			otype_q <= type_d;
			end_q   <= end_d;
			drop_q  <= drop_d;
			mal_q   <= mal_d;
			olen_q  <= accum_d;
			otlen_q <= tlen_d;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {4'd0, otlen_q, olen_q, val_q};
	assign m_axis_tuser  = {mal_q, drop_q, otype_q, role_q};
	assign m_axis_tlast  = end_q;

endmodule

// ===== tb/sv/mqtt_packet_deframer_tb.sv =====
module mqtt_packet_deframer_tb;

	localparam int LEN_BYTES_MAX = 4;
	localparam int BYTE_TARGET   = 950;
	localparam int CYCLE_LIMIT   = 200000;
	localparam int IDLE_PCT      = 21;

	// One tagged byte as the deframer should emit it
	typedef struct packed {
		logic [7:0]             value;
		mqttpd_pkg::role_t      role;
		logic [3:0]             ptype;
		logic                   pkt_end;
		logic                   dropped;
		logic                   malformed;
		mqttpd_pkg::body_len_t  blen;
		mqttpd_pkg::topic_len_t tlen;
		logic [3:0]             pad;
	} byte_tag_t;

	// Tracks the parser state and queues the tag expected for every accepted byte
	class tag_board;
		byte_tag_t              due[$];
		int                     faults;
		mqttpd_pkg::phase_t     ph;
		logic [3:0]             cur_type;
		mqttpd_pkg::body_len_t  acc;
		logic [2:0]             nseen;
		mqttpd_pkg::body_len_t  left;
		mqttpd_pkg::topic_len_t tlen;
		mqttpd_pkg::topic_len_t tleft;
		logic                   bad;

		function new();
			faults   = 0;
			ph       = mqttpd_pkg::PH_HEADER;
			cur_type = '0;
			acc      = '0;
			nseen    = '0;
			left     = '0;
			tlen     = '0;
			tleft    = '0;
			bad      = 1'b0;
		endfunction

		function void note_byte(logic [7:0] b);
			byte_tag_t t;
			t       = '0;
			t.value = b;
			case (ph)
				mqttpd_pkg::PH_LENGTH: begin
					t.role = mqttpd_pkg::ROLE_LENGTH;
					acc    = acc | (mqttpd_pkg::body_len_t'(b[6:0]) << (7 * nseen[1:0]));
					nseen  = nseen + 3'd1;
					if (b[7]) begin
						if (nseen >= LEN_BYTES_MAX) begin
							t.malformed = 1'b1;
							ph          = mqttpd_pkg::PH_HEADER;
						end
					end else begin
						left = acc;
						if (left == 0) begin
							if (cur_type == mqttpd_pkg::TYPE_PUBLISH)
								t.dropped = 1'b1;
							else
								t.pkt_end = 1'b1;
							ph = mqttpd_pkg::PH_HEADER;
						end else begin
							ph = (cur_type == mqttpd_pkg::TYPE_PUBLISH) ?
								mqttpd_pkg::PH_TLEN_HI : mqttpd_pkg::PH_SKIP;
						end
					end
				end
				mqttpd_pkg::PH_TLEN_HI: begin
					t.role = mqttpd_pkg::ROLE_TLEN;
					tlen   = {b, 8'h00};
					left   = left - 1'b1;
					if (left == 0) begin
						t.dropped = 1'b1;
						ph        = mqttpd_pkg::PH_HEADER;
					end else begin
						ph = mqttpd_pkg::PH_TLEN_LO;
					end
				end
				mqttpd_pkg::PH_TLEN_LO: begin
					t.role = mqttpd_pkg::ROLE_TLEN;
					tlen   = tlen | {8'h00, b};
					tleft  = tlen;
					left   = left - 1'b1;
					if (mqttpd_pkg::body_len_t'(tlen) > left) begin
						bad = 1'b1;
						if (left == 0) begin
							t.dropped = 1'b1;
							ph        = mqttpd_pkg::PH_HEADER;
						end else begin
							ph = mqttpd_pkg::PH_SKIP;
						end
					end else if (left == 0) begin
						t.pkt_end = 1'b1;
						ph        = mqttpd_pkg::PH_HEADER;
					end else begin
						ph = (tleft != 0) ? mqttpd_pkg::PH_TOPIC : mqttpd_pkg::PH_PAYLOAD;
					end
				end
				mqttpd_pkg::PH_TOPIC: begin
					t.role = mqttpd_pkg::ROLE_TOPIC;
					tleft  = tleft - 1'b1;
					left   = left - 1'b1;
					if (left == 0) begin
						t.pkt_end = 1'b1;
						ph        = mqttpd_pkg::PH_HEADER;
					end else if (tleft == 0) begin
						ph = mqttpd_pkg::PH_PAYLOAD;
					end
				end
				mqttpd_pkg::PH_PAYLOAD: begin
					t.role = mqttpd_pkg::ROLE_PAYLOAD;
					left   = left - 1'b1;
					if (left == 0) begin
						t.pkt_end = 1'b1;
						ph        = mqttpd_pkg::PH_HEADER;
					end
				end
				mqttpd_pkg::PH_SKIP: begin
					t.role = bad ? mqttpd_pkg::ROLE_DROP : mqttpd_pkg::ROLE_SKIP;
					left   = left - 1'b1;
					if (left == 0) begin
						if (bad)
							t.dropped = 1'b1;
						else
							t.pkt_end = 1'b1;
						ph = mqttpd_pkg::PH_HEADER;
					end
				end
				default: begin
					t.role   = mqttpd_pkg::ROLE_HEADER;
					cur_type = b[7:4];
					acc      = '0;
					nseen    = '0;
					left     = '0;
					tlen     = '0;
					tleft    = '0;
					bad      = 1'b0;
					ph       = mqttpd_pkg::PH_LENGTH;
				end
			endcase
			t.ptype = cur_type;
			t.blen  = acc;
			t.tlen  = tlen;
			due.push_back(t);
		endfunction

		function void field(string name, logic [31:0] e, logic [31:0] a);
			if (e !== a) begin
				faults++;
				$display("%0t mismatch %s: expected %0h actual %0h", $time, name, e, a);
			end
		endfunction

		function void check_tag(logic [55:0] data, logic [8:0] user, logic last);
			byte_tag_t e;
			if (due.size() == 0) begin
				faults++;
				$display("%0t unexpected result: expected none actual data %0h user %0h",
					$time, data, user);
				return;
			end
			e = due.pop_front();
			field("byte_value", e.value, data[7:0]);
			field("body_length", e.blen, data[35:8]);
			field("topic_length", e.tlen, data[51:36]);
			field("tdata_pad", e.pad, data[55:52]);
			field("byte_role", e.role, user[2:0]);
			field("packet_type", e.ptype, user[6:3]);
			field("packet_dropped", e.dropped, user[7]);
			field("length_malformed", e.malformed, user[8]);
			field("packet_end", e.pkt_end, last);
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [55:0] m_axis_tdata;
	logic [8:0]  m_axis_tuser;
	logic        m_axis_tlast;

	tag_board    board;
	logic [7:0]  frame_q[$];
	int          bytes_sent;
	int          cycles;
	bit          calm;

	mqtt_packet_deframer #(
		.MAX_LENGTH_BYTES(LEN_BYTES_MAX)
	) u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.m_axis_tlast (m_axis_tlast)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Receiver: stalls about one cycle in five, never inside the calm window
	always @(posedge clk) begin
		m_axis_tready <= calm ? 1'b1 : ($urandom_range(99) >= IDLE_PCT);
	end

	// Monitor: both handshakes are sampled at the edge, before any update lands.
	// The input transaction feeds the predictor, the output transaction is checked.
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready)
				board.note_byte(s_axis_tdata);
			if (m_axis_tvalid && m_axis_tready)
				board.check_tag(m_axis_tdata, m_axis_tuser, m_axis_tlast);
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// Drive one byte; returns at the edge where the transaction completed
	task automatic send_byte(logic [7:0] b);
		calm = (bytes_sent >= 400) && (bytes_sent < 600);
		if (!calm && ($urandom_range(99) < IDLE_PCT)) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata  <= 8'($urandom);
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= b;
		do
			@(posedge clk);
		while (!s_axis_tready);
		bytes_sent++;
	endtask

	task automatic send_frame();
		foreach (frame_q[i])
			send_byte(frame_q[i]);
		frame_q.delete();
	endtask

	// Header, remaining length (optionally padded with zero groups up to four
	// bytes) and body. For PUBLISH the first two body bytes carry the topic length,
	// whether or not it fits the body.
	function automatic void build_frame(logic [3:0] ptype, logic [3:0] flags,
		int unsigned blen, logic [15:0] tlen, int pad);
		int          groups;
		int          total;
		int unsigned v;
		logic [7:0]  g;
		frame_q.push_back({ptype, flags});
		groups = 1;
		v      = blen >> 7;
		while (v != 0) begin
			groups++;
			v = v >> 7;
		end
		total = groups + pad;
		if (total > LEN_BYTES_MAX)
			total = LEN_BYTES_MAX;
		for (int i = 0; i < total; i++) begin
			g[6:0] = 7'(blen >> (7 * i));
			g[7]   = (i < total - 1);
			frame_q.push_back(g);
		end
		for (int unsigned i = 0; i < blen; i++) begin
			if (ptype == mqttpd_pkg::TYPE_PUBLISH && i == 0)
				frame_q.push_back(tlen[15:8]);
			else if (ptype == mqttpd_pkg::TYPE_PUBLISH && i == 1)
				frame_q.push_back(tlen[7:0]);
			else
				frame_q.push_back(8'($urandom));
		end
	endfunction

	// Four length bytes, all with the continuation bit set
	function automatic void build_bad_length(logic [7:0] hdr, bit all_ones);
		frame_q.push_back(hdr);
		for (int i = 0; i < LEN_BYTES_MAX; i++)
			frame_q.push_back(all_ones ? 8'hFF : {1'b1, 7'($urandom)});
	endfunction

	function automatic logic [3:0] other_type();
		logic [3:0] t;
		t = 4'($urandom);
		if (t == mqttpd_pkg::TYPE_PUBLISH)
			t = 4'd4;
		return t;
	endfunction

	initial begin
		int          kind;
		int unsigned blen;
		int unsigned tl;
		int          pad;
		logic [15:0] tlen;

		board         = new();
		clk           = 1'b0;
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		m_axis_tready = 1'b0;
		bytes_sent    = 0;
		cycles        = 0;
		calm          = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: well-formed PUBLISH with a one-byte topic and one payload byte
		build_frame(mqttpd_pkg::TYPE_PUBLISH, 4'h0, 4, 16'd1, 0);
		// empty body on a non-PUBLISH type ends on the length byte
		build_frame(4'hC, 4'h0, 0, 16'd0, 0);
		// empty PUBLISH is dropped on its length byte
		build_frame(mqttpd_pkg::TYPE_PUBLISH, 4'hF, 0, 16'd0, 0);
		// body ends inside the topic length
		build_frame(mqttpd_pkg::TYPE_PUBLISH, 4'h1, 1, 16'd0, 0);
		// topic overrun with nothing after the topic length
		build_frame(mqttpd_pkg::TYPE_PUBLISH, 4'h0, 2, 16'd5, 0);
		// widest topic length, overrun with a dropped byte after it
		build_frame(mqttpd_pkg::TYPE_PUBLISH, 4'h0, 3, 16'hFFFF, 0);
		// malformed length with every bit set, type nibble 15
		build_bad_length(8'hF0, 1'b1);
		send_frame();

		// Random part: mostly well-formed packets with random content
		while (bytes_sent < BYTE_TARGET) begin
			kind = $urandom_range(99);
			pad  = ($urandom_range(4) == 0) ? $urandom_range(1, 3) : 0;
			if (kind < 50) begin
				tl   = $urandom_range(0, 8);
				blen = 2 + tl + (($urandom_range(19) == 0) ? $urandom_range(0, 200)
					: $urandom_range(0, 12));
				build_frame(mqttpd_pkg::TYPE_PUBLISH, 4'($urandom), blen, 16'(tl), pad);
			end else if (kind < 75) begin
				blen = ($urandom_range(19) == 0) ? $urandom_range(0, 300)
					: $urandom_range(0, 16);
				build_frame(other_type(), 4'($urandom), blen, 16'd0, pad);
			end else if (kind < 87) begin
				// topic that does not fit the body, sometimes by a single byte
				blen = $urandom_range(0, 6);
				tlen = ($urandom_range(1) == 0 && blen >= 2) ? 16'(blen - 1) : 16'($urandom);
				build_frame(mqttpd_pkg::TYPE_PUBLISH, 4'($urandom), blen, tlen, pad);
			end else if (kind < 95) begin
				build_bad_length(8'($urandom), $urandom_range(3) == 0);
			end else begin
				// random type and body bytes, topic length included
				build_frame(4'($urandom), 4'($urandom), $urandom_range(0, 127),
					16'($urandom), 0);
			end
			send_frame();
		end

		// Largest legal remaining length; left open at the end of the run
		frame_q.push_back({mqttpd_pkg::TYPE_PUBLISH, 4'($urandom)});
		frame_q.push_back(8'hFF);
		frame_q.push_back(8'hFF);
		frame_q.push_back(8'hFF);
		frame_q.push_back(8'h7F);
		repeat (6) frame_q.push_back(8'($urandom));
		send_frame();
		s_axis_tvalid <= 1'b0;

		// Drain; the watchdog bounds this wait
		while (board.due.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		if (board.faults == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
